// ----- hdl/triangle_face_normal_assert.svh -----
// Assertion macros for the triangle normal RTL.
`ifndef TRIANGLE_FACE_NORMAL_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TFN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tfn_pkg.sv -----
// Shared types and constants for the triangle face normal block.
package tfn_pkg;
    localparam int FIELD_BITS  = 16;   // coordinate and normal field width
    localparam int ALIGN_BITS  = 31;   // aligned magnitude width, top bit 30
    localparam int SUM_BITS    = 64;   // sum of squares width
    localparam int SQRT_STEPS  = 32;   // one result bit per step
    localparam int ROOT_BITS   = 32;   // root fits below 2^32

    typedef logic signed [FIELD_BITS-1:0] t_coord;
    typedef logic signed [FIELD_BITS-1:0] t_normal;
endpackage

// ----- hdl/tfn_tri_if.sv -----
// Triangle input and normal output channel interfaces.
interface tfn_tri_if import tfn_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord v0_x, v0_y, v0_z;
    t_coord v1_x, v1_y, v1_z;
    t_coord v2_x, v2_y, v2_z;

    modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, input ready);
    modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, output ready);
endinterface

interface tfn_nrm_if import tfn_pkg::*; ();
    logic    valid;
    logic    ready;
    t_normal normal_x, normal_y, normal_z;
    logic    degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ----- hdl/triangle_face_normal.sv -----
// Triangle face normal: edge cross product normalized to a signed unit vector.
//
// Each triangle beat (three vertices, signed Q8.8) yields one normal beat: the
// cross product (v2-v0)x(v1-v0), rescaled to unit length in signed Q1.14 (more
// generally NORMAL_FRAC_BITS fraction bits, each component rounded half up),
// plus a degenerate flag that is set, with a zero normal, when the cross
// product vanishes. The block takes one triangle every cycle while the pipeline
// is not full or the output is ready. Its depth is set mostly by the bit-serial
// square root (32 stages, one root bit each) followed by the restoring
// dividers (NORMAL_FRAC_BITS+1 stages, one quotient bit each). Every stage has
// its own valid bit and advances whenever the stage after it is empty or
// moving, so bubbles close up behind a stalled output and the input keeps
// accepting until the whole pipeline is full. Coordinates are sign-extended
// from bit COORD_WIDTH-1 of each field; no state survives between triangles.
module triangle_face_normal
    import tfn_pkg::*;
#(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tfn_tri_if.sink        i_tri,
    tfn_nrm_if.source      o_nrm
);
`include "triangle_face_normal_assert.svh"

    // ------------------------------------------------------------------
    // Widths
    // ------------------------------------------------------------------
    localparam int CW = COORD_WIDTH;
    localparam int F  = NORMAL_FRAC_BITS;
    localparam int IW = (CW > FIELD_BITS) ? CW : FIELD_BITS; // extension width
    localparam int EW = CW + 1;          // edge
    localparam int PW = 2 * EW;          // edge product
    localparam int MW = PW + 1;          // cross product
    localparam int LW = $clog2(MW + 1);  // bit length of cross magnitude
    localparam int SW = MW + ALIGN_BITS; // alignment shifter
    localparam int NW = ALIGN_BITS + F + 1; // dividend
    localparam int QW = F + 1;           // quotient

    // Stage map
    localparam int ST_EDGE  = 0;
    localparam int ST_PROD  = 1;
    localparam int ST_CROSS = 2;
    localparam int ST_MAG   = 3;
    localparam int ST_LEN   = 4;
    localparam int ST_ALIGN = 5;
    localparam int ST_SQR   = 6;
    localparam int ST_SUM   = 7;
    localparam int ST_SQRT0 = 8;
    localparam int ST_PREP  = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_DIV0  = ST_PREP + 1;
    localparam int ST_OUT   = ST_DIV0 + QW;
    localparam int NS       = ST_OUT + 1;

    // ------------------------------------------------------------------
    // Flow control: stage k loads when it is empty or its content moves on
    // ------------------------------------------------------------------
    logic [NS-1:0] r_v;
    logic [NS:0]   en;

    assign en[NS] = o_nrm.ready;
    for (genvar k = 0; k < NS; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= (k == 0) ? i_tri.valid : r_v[(k > 0) ? k - 1 : 0];
                end
            end
        end
    end

    assign i_tri.ready = en[0];

    function automatic logic signed [CW-1:0] sext(input t_coord x);
        logic [IW-1:0] z;
        z = IW'($unsigned(x));
        return $signed(z[CW-1:0]);
    endfunction

    // ------------------------------------------------------------------
    // Edges e10 = v1-v0, e20 = v2-v0
    // ------------------------------------------------------------------
    logic signed [CW-1:0] w0x, w0y, w0z, w1x, w1y, w1z, w2x, w2y, w2z;
    logic signed [EW-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;

    always_comb begin
        w0x = sext(i_tri.v0_x); w0y = sext(i_tri.v0_y); w0z = sext(i_tri.v0_z);
        w1x = sext(i_tri.v1_x); w1y = sext(i_tri.v1_y); w1z = sext(i_tri.v1_z);
        w2x = sext(i_tri.v2_x); w2y = sext(i_tri.v2_y); w2z = sext(i_tri.v2_z);
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_EDGE]) begin
            r_ax <= EW'(w1x) - EW'(w0x);
            r_ay <= EW'(w1y) - EW'(w0y);
            r_az <= EW'(w1z) - EW'(w0z);
            r_bx <= EW'(w2x) - EW'(w0x);
            r_by <= EW'(w2y) - EW'(w0y);
            r_bz <= EW'(w2z) - EW'(w0z);
        end
    end

    // ------------------------------------------------------------------
    // Edge products, one per term of the cross product
    // ------------------------------------------------------------------
    logic signed [PW-1:0] r_p [6];

    always_ff @(posedge i_clk) begin
        if (en[ST_PROD]) begin
            r_p[0] <= r_by * r_az;
            r_p[1] <= r_bz * r_ay;
            r_p[2] <= r_bz * r_ax;
            r_p[3] <= r_bx * r_az;
            r_p[4] <= r_bx * r_ay;
            r_p[5] <= r_by * r_ax;
        end
    end

    // ------------------------------------------------------------------
    // Cross product c = e20 x e10
    // ------------------------------------------------------------------
    logic signed [MW-1:0] r_c [3];

    always_ff @(posedge i_clk) begin
        if (en[ST_CROSS]) begin
            for (int i = 0; i < 3; i++) begin
                r_c[i] <= MW'(r_p[2*i]) - MW'(r_p[2*i+1]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sign and magnitude
    // ------------------------------------------------------------------
    logic [MW-1:0] r_m  [3];
    logic [2:0]    r_mg_neg;

    always_ff @(posedge i_clk) begin
        if (en[ST_MAG]) begin
            for (int i = 0; i < 3; i++) begin
                r_mg_neg[i] <= r_c[i][MW-1];
                r_m[i]      <= r_c[i][MW-1] ? MW'(-r_c[i]) : MW'(r_c[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Bit length of the largest magnitude (= bit length of their OR)
    // ------------------------------------------------------------------
    logic [MW-1:0] or_m;
    logic [LW-1:0] len;
    logic [LW-1:0] r_len;
    logic [MW-1:0] r_ln_m [3];
    logic [2:0]    r_ln_neg;

    always_comb begin
        or_m = r_m[0] | r_m[1] | r_m[2];
        len  = '0;
        for (int b = 0; b < MW; b++) begin
            if (or_m[b]) len = LW'(b + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_LEN]) begin
            r_len    <= len;
            r_ln_m   <= r_m;
            r_ln_neg <= r_mg_neg;
        end
    end

    // ------------------------------------------------------------------
    // Common shift putting the top set bit at bit 30; right shift truncates
    // ------------------------------------------------------------------
    logic [ALIGN_BITS-1:0] al_s [3];
    logic [ALIGN_BITS-1:0] r_al_s [3];
    logic [2:0]            r_al_neg;
    logic                  r_al_dg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_len <= LW'(ALIGN_BITS)) begin
                al_s[i] = ALIGN_BITS'(SW'(r_ln_m[i]) << (LW'(ALIGN_BITS) - r_len));
            end else begin
                al_s[i] = ALIGN_BITS'(r_ln_m[i] >> (r_len - LW'(ALIGN_BITS)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_ALIGN]) begin
            r_al_s   <= al_s;
            r_al_neg <= r_ln_neg;
            r_al_dg  <= (r_len == '0);
        end
    end

    // ------------------------------------------------------------------
    // Squares, then their sum
    // ------------------------------------------------------------------
    logic [2*ALIGN_BITS-1:0] r_sqr [3];
    logic [ALIGN_BITS-1:0]   r_sr_s [3];
    logic [2:0]              r_sr_neg;
    logic                    r_sr_dg;
    logic [SUM_BITS-1:0]     r_sum;
    logic [ALIGN_BITS-1:0]   r_su_s [3];
    logic [2:0]              r_su_neg;
    logic                    r_su_dg;

    always_ff @(posedge i_clk) begin
        if (en[ST_SQR]) begin
            for (int i = 0; i < 3; i++) begin
                r_sqr[i] <= r_al_s[i] * r_al_s[i];
            end
            r_sr_s   <= r_al_s;
            r_sr_neg <= r_al_neg;
            r_sr_dg  <= r_al_dg;
        end
        if (en[ST_SUM]) begin
            r_sum    <= SUM_BITS'(r_sqr[0]) + SUM_BITS'(r_sqr[1]) + SUM_BITS'(r_sqr[2]);
            r_su_s   <= r_sr_s;
            r_su_neg <= r_sr_neg;
            r_su_dg  <= r_sr_dg;
        end
    end

    // ------------------------------------------------------------------
    // Integer square root, one result bit per stage (digit-by-digit)
    // ------------------------------------------------------------------
    logic [SUM_BITS-1:0]   r_sq_x   [SQRT_STEPS];
    logic [SUM_BITS-1:0]   r_sq_r   [SQRT_STEPS];
    logic [ALIGN_BITS-1:0] r_sq_s   [SQRT_STEPS][3];
    logic [2:0]            r_sq_neg [SQRT_STEPS];
    logic                  r_sq_dg  [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [SUM_BITS-1:0] BIT = SUM_BITS'(1) << (SUM_BITS - 2 - 2 * k);
        localparam int PREV = (k > 0) ? k - 1 : 0;
        logic [SUM_BITS-1:0]   x_in, r_in, t;
        logic [ALIGN_BITS-1:0] s_in [3];
        logic [2:0]            neg_in;
        logic                  dg_in;

        always_comb begin
            if (k == 0) begin
                x_in = r_sum;   r_in = '0;          s_in = r_su_s;
                neg_in = r_su_neg; dg_in = r_su_dg;
            end else begin
                x_in = r_sq_x[PREV]; r_in = r_sq_r[PREV]; s_in = r_sq_s[PREV];
                neg_in = r_sq_neg[PREV]; dg_in = r_sq_dg[PREV];
            end
            t = r_in + BIT;
        end

        always_ff @(posedge i_clk) begin
            if (en[ST_SQRT0+k]) begin
                if (x_in >= t) begin
                    r_sq_x[k] <= x_in - t;
                    r_sq_r[k] <= (r_in >> 1) + BIT;
                end else begin
                    r_sq_x[k] <= x_in;
                    r_sq_r[k] <= r_in >> 1;
                end
                r_sq_s[k]   <= s_in;
                r_sq_neg[k] <= neg_in;
                r_sq_dg[k]  <= dg_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Dividends s*2^F + floor(r/2)
    // ------------------------------------------------------------------
    logic [SUM_BITS-1:0]  root;
    logic [NW-1:0]        r_pp_num [3];
    logic [ROOT_BITS-1:0] r_pp_r;
    logic [2:0]           r_pp_neg;
    logic                 r_pp_dg;

    assign root = r_sq_r[SQRT_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (en[ST_PREP]) begin
            for (int i = 0; i < 3; i++) begin
                r_pp_num[i] <= (NW'(r_sq_s[SQRT_STEPS-1][i]) << F)
                             + NW'(root[ROOT_BITS-1:1]);
            end
            r_pp_r   <= root[ROOT_BITS-1:0];
            r_pp_neg <= r_sq_neg[SQRT_STEPS-1];
            r_pp_dg  <= r_sq_dg[SQRT_STEPS-1];
        end
    end

    // ------------------------------------------------------------------
    // Restoring division, one quotient bit per stage, MSB first
    // ------------------------------------------------------------------
    logic [NW-1:0]        r_dv_rem [QW][3];
    logic [QW-1:0]        r_dv_q   [QW][3];
    logic [ROOT_BITS-1:0] r_dv_r   [QW];
    logic [2:0]           r_dv_neg [QW];
    logic                 r_dv_dg  [QW];

    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int SH   = F - j;
        localparam int PREV = (j > 0) ? j - 1 : 0;
        logic [NW-1:0]        rem_in [3];
        logic [QW-1:0]        q_in   [3];
        logic [ROOT_BITS-1:0] r_in;
        logic [2:0]           neg_in;
        logic                 dg_in;
        logic [NW:0]          dvs;

        always_comb begin
            if (j == 0) begin
                rem_in = r_pp_num; r_in = r_pp_r; neg_in = r_pp_neg; dg_in = r_pp_dg;
                for (int i = 0; i < 3; i++) q_in[i] = '0;
            end else begin
                rem_in = r_dv_rem[PREV]; q_in = r_dv_q[PREV]; r_in = r_dv_r[PREV];
                neg_in = r_dv_neg[PREV]; dg_in = r_dv_dg[PREV];
            end
            dvs = (NW+1)'(r_in) << SH;
        end

        always_ff @(posedge i_clk) begin
            if (en[ST_DIV0+j]) begin
                for (int i = 0; i < 3; i++) begin
                    if ((NW+1)'(rem_in[i]) >= dvs) begin
                        r_dv_rem[j][i] <= NW'((NW+1)'(rem_in[i]) - dvs);
                        r_dv_q[j][i]   <= q_in[i] | (QW'(1) << SH);
                    end else begin
                        r_dv_rem[j][i] <= rem_in[i];
                        r_dv_q[j][i]   <= q_in[i];
                    end
                end
                r_dv_r[j]   <= r_in;
                r_dv_neg[j] <= neg_in;
                r_dv_dg[j]  <= dg_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: sign, field truncation, degenerate zeroing
    // ------------------------------------------------------------------
    t_normal r_nrm [3];
    logic    r_dg;

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            for (int i = 0; i < 3; i++) begin
                if (r_dv_dg[QW-1]) begin
                    r_nrm[i] <= '0;
                end else if (r_dv_neg[QW-1][i]) begin
                    r_nrm[i] <= FIELD_BITS'(-(FIELD_BITS+QW)'(r_dv_q[QW-1][i]));
                end else begin
                    r_nrm[i] <= FIELD_BITS'((FIELD_BITS+QW)'(r_dv_q[QW-1][i]));
                end
            end
            r_dg <= r_dv_dg[QW-1];
        end
    end

    assign o_nrm.valid      = r_v[NS-1];
    assign o_nrm.normal_x   = r_nrm[0];
    assign o_nrm.normal_y   = r_nrm[1];
    assign o_nrm.normal_z   = r_nrm[2];
    assign o_nrm.degenerate = r_dg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `TFN_ASSERT_NOW(a_dg_zero, o_nrm.valid && o_nrm.degenerate, r_nrm[0] == '0 && r_nrm[1] == '0 && r_nrm[2] == '0, "degenerate beat with nonzero normal")
    `TFN_ASSERT_NOW(a_ready_when_drained, !r_v[NS-1], i_tri.ready, "input stalled with empty output stage")
    `TFN_ASSERT_NEXT(a_hold_stalled, r_v[NS-1] && !o_nrm.ready, r_v[NS-1], "stalled result dropped")
    `TFN_ASSERT_NOW(a_root_range, r_v[ST_SQRT0+SQRT_STEPS-1] && !r_sq_dg[SQRT_STEPS-1], root >= (SUM_BITS'(1) << (ALIGN_BITS - 1)), "root below 2^30 for nonzero vector")

endmodule

// ----- test/tb_triangle_face_normal.sv -----
// Testbench for triangle_face_normal: directed and random triangles, checked vs predictor or table.
module tb_triangle_face_normal;
    import tfn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFRAC     = 14;
    localparam int LATENCY   = 43 + NFRAC;
    localparam int N_RANDOM  = 1630;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        t_coord v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
    } tri_t;

    typedef struct packed {
        t_normal nx, ny, nz;
        logic    degen;
    } nrm_t;

    // Directed row: triangle, and optionally a typed-in expected normal.
    typedef struct {
        tri_t tri_in;
        bit   has_exp;
        nrm_t exp_nrm;
    } row_t;

    logic i_clk;
    logic i_rst_n;
    tfn_tri_if tri_ch ();
    tfn_nrm_if nrm_ch ();

    triangle_face_normal #(.COORD_WIDTH(16), .NORMAL_FRAC_BITS(NFRAC)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tri  (tri_ch.sink),
        .o_nrm  (nrm_ch.source)
    );

    nrm_t   expected_normals[$];
    int     n_errors = 0;
    longint n_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle limit guards against a hung pipeline.
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report(input string what);
        n_errors++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    function automatic int bit_length(input logic [63:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++)
            if (v[i]) n = i + 1;
        return n;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Cross product e20 x e10 of the edges, scaled to a unit vector in Q1.14.
    function automatic nrm_t face_normal(input tri_t t);
        longint ax, ay, az, bx, by, bz;
        longint c[3];
        logic [63:0] mag[3], s[3], sum, r, q;
        int len;
        nrm_t n;
        ax = longint'(t.v1_x) - t.v0_x;
        ay = longint'(t.v1_y) - t.v0_y;
        az = longint'(t.v1_z) - t.v0_z;
        bx = longint'(t.v2_x) - t.v0_x;
        by = longint'(t.v2_y) - t.v0_y;
        bz = longint'(t.v2_z) - t.v0_z;
        c[0] = by * az - bz * ay;
        c[1] = bz * ax - bx * az;
        c[2] = bx * ay - by * ax;
        len = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (c[i] < 0) ? -c[i] : c[i];
            if (bit_length(mag[i]) > len) len = bit_length(mag[i]);
        end
        n = '0;
        if (len == 0) begin
            n.degen = 1'b1;
            return n;
        end
        for (int i = 0; i < 3; i++) begin
            if (len <= 31) s[i] = mag[i] << (31 - len);
            else           s[i] = mag[i] >> (len - 31);
        end
        sum = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
        r = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((s[i] << NFRAC) + (r >> 1)) / r;
            if (c[i] < 0) q = -q;
            if (i == 0) n.nx = q[15:0];
            if (i == 1) n.ny = q[15:0];
            if (i == 2) n.nz = q[15:0];
        end
        return n;
    endfunction

    function automatic tri_t random_tri();
        tri_t t;
        int mode;
        mode = $urandom_range(0, 9);
        t = tri_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if (mode == 0) begin
            // small triangle near the origin: short edges
            t.v0_x = $urandom_range(0, 15) - 8; t.v0_y = $urandom_range(0, 15) - 8;
            t.v0_z = $urandom_range(0, 15) - 8; t.v1_x = $urandom_range(0, 15) - 8;
            t.v1_y = $urandom_range(0, 15) - 8; t.v1_z = $urandom_range(0, 15) - 8;
            t.v2_x = $urandom_range(0, 15) - 8; t.v2_y = $urandom_range(0, 15) - 8;
            t.v2_z = $urandom_range(0, 15) - 8;
        end else if (mode == 1) begin
            // collinear: v2 repeats v0 or v1
            if ($urandom_range(0, 1)) {t.v2_x, t.v2_y, t.v2_z} = {t.v0_x, t.v0_y, t.v0_z};
            else                      {t.v2_x, t.v2_y, t.v2_z} = {t.v1_x, t.v1_y, t.v1_z};
        end else if (mode == 2) begin
            // axis-aligned plane
            t.v1_z = t.v0_z; t.v2_z = t.v0_z;
        end
        return t;
    endfunction

    // Output side: random backpressure, short stalls mostly, a few long ones.
    initial begin
        nrm_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                nrm_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 40) == 0) begin
                nrm_ch.ready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(negedge i_clk);
            end else begin
                nrm_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        nrm_t got, want;
        if (i_rst_n && nrm_ch.valid && nrm_ch.ready) begin
            got = '{nrm_ch.normal_x, nrm_ch.normal_y, nrm_ch.normal_z, nrm_ch.degenerate};
            if (expected_normals.size() == 0) begin
                report("normal beat with no triangle outstanding");
            end else begin
                want = expected_normals.pop_front();
                if (got.nx !== want.nx)
                    report($sformatf("normal_x %0d exp %0d", got.nx, want.nx));
                if (got.ny !== want.ny)
                    report($sformatf("normal_y %0d exp %0d", got.ny, want.ny));
                if (got.nz !== want.nz)
                    report($sformatf("normal_z %0d exp %0d", got.nz, want.nz));
                if (got.degen !== want.degen)
                    report($sformatf("degenerate %0b exp %0b", got.degen, want.degen));
            end
        end
    end

    // Drive one triangle beat; the beat is held until accepted.
    task automatic send_tri(input tri_t t, input bit has_exp, input nrm_t exp_n);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            tri_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tri_ch.valid <= 1'b1;
        {tri_ch.v0_x, tri_ch.v0_y, tri_ch.v0_z, tri_ch.v1_x, tri_ch.v1_y, tri_ch.v1_z,
         tri_ch.v2_x, tri_ch.v2_y, tri_ch.v2_z} <= t;
        @(posedge i_clk);
        while (!tri_ch.ready) @(posedge i_clk);
        expected_normals.push_back(has_exp ? exp_n : face_normal(t));
        @(negedge i_clk);
    endtask

    localparam t_coord MAXC = 16'sh7fff;
    localparam t_coord MINC = -16'sh8000;
    localparam t_normal ONE = 16'sd16384;

    row_t directed[] = '{
        // all at the origin: degenerate
        '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 1'b1}},
        // all vertices equal at the extremes: degenerate
        '{'{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC}, 1, '{0, 0, 0, 1'b1}},
        '{'{MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC}, 1, '{0, 0, 0, 1'b1}},
        // e10 along x, e20 along y: (e20 x e10) points to -z
        '{'{0, 0, 0, 256, 0, 0, 0, 256, 0}, 1, '{0, 0, -ONE, 1'b0}},
        '{'{0, 0, 0, 0, 256, 0, 256, 0, 0}, 1, '{0, 0, ONE, 1'b0}},
        '{'{0, 0, 0, 0, 1, 0, 0, 0, 1}, 1, '{-ONE, 0, 0, 1'b0}},
        '{'{0, 0, 0, 0, 0, 1, 1, 0, 0}, 1, '{0, -ONE, 0, 1'b0}},
        // widest edges, full-scale products
        '{'{MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC}, 1, '{0, 0, -ONE, 1'b0}},
        '{'{MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MINC, MAXC}, 1, '{0, 0, -ONE, 1'b0}},
        '{'{MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MAXC, MINC}, 0, '0},
        '{'{MAXC, MINC, MAXC, MINC, MAXC, MINC, MINC, MINC, MAXC}, 0, '0},
        // collinear, nonzero edges: degenerate
        '{'{0, 0, 0, 1, 2, 3, 2, 4, 6}, 1, '{0, 0, 0, 1'b1}},
        '{'{MINC, MINC, MINC, 0, 0, 0, MAXC, MAXC, MAXC}, 0, '0},
        // diagonal normals, rounding
        '{'{0, 0, 0, 1, 0, 0, 0, 1, 1}, 0, '0},
        '{'{0, 0, 0, 1, 1, 0, 0, 1, 1}, 0, '0},
        '{'{-1, -1, -1, 1, -1, 1, -1, 1, 1}, 0, '0},
        '{'{100, -200, 300, -400, 500, -600, 700, -800, 901}, 0, '0},
        '{'{1, 2, 3, 1, 2, 4, 1, 3, 3}, 0, '0}
    };

    initial begin
        row_t rw;
        tri_ch.valid = 1'b0;
        {tri_ch.v0_x, tri_ch.v0_y, tri_ch.v0_z, tri_ch.v1_x, tri_ch.v1_y, tri_ch.v1_z,
         tri_ch.v2_x, tri_ch.v2_y, tri_ch.v2_z} = '0;
        i_rst_n   = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[k]) begin
            rw = directed[k];
            send_tri(rw.tri_in, rw.has_exp, rw.exp_nrm);
        end
        tri_ch.valid <= 1'b0;
        // hold off until the pipeline has drained completely
        while (expected_normals.size() != 0) @(negedge i_clk);

        for (int k = 0; k < N_RANDOM; k++) begin
            send_tri(random_tri(), 1'b0, '0);
        end
        tri_ch.valid <= 1'b0;

        while (expected_normals.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
